// ----- rtl/ordered_list_table_assert.svh -----
// Assertion macros for the ordered list table.
`ifndef ORDERED_LIST_TABLE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/olt_pkg.sv -----
// Shared constants, codes and control types of the ordered list table.
`default_nettype none

package olt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int ST_W     = 2;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;        // run a non-locate command on the accepted item
    logic start_scan;  // latch the search value, point at the first entry
    logic scan;        // compare one entry this cycle
  } olt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;   // output register empty or being emptied
    logic in_locate;   // offered item is a locate
    logic scan_end;    // current compare hits or is the last one
  } olt_sts_t;

endpackage

`default_nettype wire

// ----- rtl/olt_in_if.sv -----
// Input channel of the ordered list table: command, position and value.
`default_nettype none

interface olt_in_if;
  import olt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/olt_out_if.sv -----
// Output channel of the ordered list table: status, element, position, length.
`default_nettype none

interface olt_out_if;
  import olt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] element;
  logic [POS_W-1:0]         found_position;
  logic [POS_W-1:0]         length_now;

  modport source (output valid, output status, output element, output found_position,
                  output length_now, input ready);
  modport sink   (input valid, input status, input element, input found_position,
                  input length_now, output ready);
endinterface

`default_nettype wire

// ----- rtl/ordered_list_table.sv -----
// Top level of the ordered list table: controller, datapath and channel wiring.
//
//   channel  role    payload
//   in_i     sink    command, position, value
//   out_o    source  status, element, found_position, length_now
//
// Insert, delete, get, clear and unused codes are accepted and their result is
// loaded into the output register at the same edge.
// Locate walks the stored entries through the single read port, one per cycle,
// and stops at the first hit or at the last stored entry.
// rst_ni (asynchronous, active low) empties the list and the output register.
// A new item is taken only while the output register is empty or being read.
`default_nettype none

`include "ordered_list_table_assert.svh"

module ordered_list_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  olt_in_if.sink    in_i,
  olt_out_if.source out_o
);
  import olt_pkg::*;

  olt_cmd_t cmd;
  olt_sts_t sts;

  // Hold the handshake and sequence the locate scan.
  olt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Store entries, shift them, and register each result.
  olt_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .command_i        (in_i.command),
    .position_i       (in_i.position),
    .value_i          (in_i.value),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .status_o         (out_o.status),
    .element_o        (out_o.element),
    .found_position_o (out_o.found_position),
    .length_now_o     (out_o.length_now)
  );

  // No item is taken while a scan runs.
  `OLT_ASSERT_NOW(a_no_accept_in_scan, cmd.scan, !in_i.ready, "item taken during locate scan")
  // A non-locate command shows its result at the next edge.
  `OLT_ASSERT_NEXT(a_exec_result, cmd.exec, out_o.valid, "one-cycle command lost its result")
  // The scan stops once it ends and leaves a result behind.
  `OLT_ASSERT_NEXT(a_scan_stops, cmd.scan && sts.scan_end, !cmd.scan && out_o.valid,
                   "locate scan did not finish cleanly")

endmodule

`default_nettype wire

// ----- rtl/olt_ctrl.sv -----
// Controller of the ordered list table: accept items and sequence the locate scan.
`default_nettype none

module olt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  olt_pkg::olt_sts_t sts_i,
  output olt_pkg::olt_cmd_t cmd_o
);
  import olt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.slot_free;
        if (in_valid_i && sts_i.slot_free) begin
          if (sts_i.in_locate) begin
            cmd_o.start_scan = 1'b1;
            state_d          = S_SCAN;
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/olt_dp.sv -----
// Datapath of the ordered list table: entry cells, count, scan pointer, result register.
`default_nettype none

module olt_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  olt_pkg::olt_cmd_t                cmd_i,
  output olt_pkg::olt_sts_t                sts_o,
  input  logic [olt_pkg::CMD_W-1:0]        command_i,
  input  logic [olt_pkg::POS_W-1:0]        position_i,
  input  logic signed [olt_pkg::DATA_W-1:0] value_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [olt_pkg::ST_W-1:0]         status_o,
  output logic signed [olt_pkg::DATA_W-1:0] element_o,
  output logic [olt_pkg::POS_W-1:0]        found_position_o,
  output logic [olt_pkg::POS_W-1:0]        length_now_o
);
  import olt_pkg::*;

  logic [DATA_W-1:0] entries_q [CAPACITY];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q;
  logic [DATA_W-1:0] key_q;

  logic              out_valid_q;
  logic [ST_W-1:0]   status_q;
  logic [DATA_W-1:0] element_q;
  logic [POS_W-1:0]  found_q;
  logic [POS_W-1:0]  len_q;

  logic [CMP_W-1:0]  pos_ext, pos_m1, cnt_ext, idx_ext;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] rd_data;
  logic              rd_pos_ok, ins_pos_ok, full;
  logic              ins_do, del_do, clr_do;
  logic              scan_hit, scan_last, scan_fin;
  status_e           exec_status;
  logic [DATA_W-1:0] exec_element;

  assign pos_ext    = CMP_W'(position_i);
  assign pos_m1     = pos_ext - 1'b1;
  assign cnt_ext    = CMP_W'(cnt_q);
  assign idx_ext    = CMP_W'(idx_q);
  assign full       = (cnt_ext == CMP_W'(CAPACITY));
  assign rd_pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + 1'b1);

  // One read port, shared by get/delete and the locate scan.
  assign rd_idx  = cmd_i.scan ? idx_q : pos_m1[IDX_W-1:0];
  assign rd_data = entries_q[rd_idx];

  assign scan_hit  = (cnt_q != '0) && (rd_data == key_q);
  assign scan_last = (idx_ext + 1'b1 >= cnt_ext);
  assign scan_fin  = cmd_i.scan && (scan_hit || scan_last);

  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.in_locate = (command_i == CMD_LOCATE);
  assign sts_o.scan_end  = scan_hit || scan_last;

  always_comb begin
    exec_status  = ST_OK;
    exec_element = '0;
    ins_do       = 1'b0;
    del_do       = 1'b0;
    clr_do       = 1'b0;
    unique case (command_i)
      CMD_INSERT: begin
        if (!ins_pos_ok) begin
          exec_status = ST_BAD_POS;
        end else if (full) begin
          exec_status = ST_FULL;
        end else begin
          ins_do = cmd_i.exec;
        end
      end
      CMD_DELETE: begin
        if (!rd_pos_ok) begin
          exec_status = ST_BAD_POS;
        end else begin
          exec_element = rd_data;
          del_do       = cmd_i.exec;
        end
      end
      CMD_GET: begin
        if (!rd_pos_ok) begin
          exec_status = ST_BAD_POS;
        end else begin
          exec_element = rd_data;
        end
      end
      CMD_CLEAR: begin
        clr_do = cmd_i.exec;
      end
      default: begin
        // locate never runs here; unused codes change nothing
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ins_do) begin
      cnt_d = cnt_q + 1'b1;
    end else if (del_do) begin
      cnt_d = cnt_q - 1'b1;
    end else if (clr_do) begin
      cnt_d = '0;
    end
  end

  // Insert shifts cells above the slot up; delete shifts cells from the slot on down.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (ins_do) begin
        if (CMP_W'(k) == pos_m1) begin
          entries_q[k] <= value_i;
        end else if (CMP_W'(k) > pos_m1) begin
          if (k > 0) begin
            entries_q[k] <= entries_q[(k > 0) ? k - 1 : 0];
          end
        end
      end else if (del_do) begin
        if (k < CAPACITY - 1) begin
          if (CMP_W'(k) >= pos_m1) begin
            entries_q[k] <= entries_q[(k < CAPACITY - 1) ? k + 1 : k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.start_scan) begin
        idx_q <= '0;
      end else if (cmd_i.scan) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.exec || scan_fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_scan) begin
      key_q <= value_i;
    end
    if (cmd_i.exec) begin
      status_q  <= exec_status;
      element_q <= exec_element;
      found_q   <= '0;
      len_q     <= POS_W'(cnt_d);
    end else if (scan_fin) begin
      status_q  <= scan_hit ? ST_OK : ST_NOT_FOUND;
      element_q <= '0;
      found_q   <= scan_hit ? POS_W'(idx_ext + 1'b1) : '0;
      len_q     <= POS_W'(cnt_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign element_o        = element_q;
  assign found_position_o = found_q;
  assign length_now_o     = len_q;

endmodule

`default_nettype wire
